@@ rtl/vtp_pkg.sv @@
// ----------------------------------------------------------------------------
// vtp_pkg
// shared types, codes and saturation helper for the vertex transform block
// ----------------------------------------------------------------------------
`default_nettype none

package vtp_pkg;

  // input item codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  // configuration register indexes
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;

  // data riding along the divider chain
  typedef struct packed {
    logic             skip;
    logic [2:0]       neg;
    logic [2:0][31:0] pv;
    logic [31:0]      pw;
  } div_side_t;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'(MAX32)) r = MAX32;
    else if (v < 66'(MIN32)) r = MIN32;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/vertex_transform_project_core.sv @@
// ----------------------------------------------------------------------------
// vertex_transform_project_core
// fixed-point vertex transform, projection, perspective divide and viewport
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid in_ready op coef_index coef_value| in
//          | in_x in_y in_z in_w                       |
//  result  | out_valid out_ready screen_x screen_y     | out
//          | depth_z clip_w divide_skipped             |
//  config  | cfg_valid cfg_ready cfg_index cfg_data    | in
//
//  one item per cycle while the result is not stalled; the divider chain
//  resolves one quotient bit per cell
//  the whole pipeline advances together; a stalled result freezes it
//  reset clears the valid bits and restores the viewport size
//  matrix contents are undefined until loaded
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_project_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic [4:0]         coef_index,
  input  wire logic signed [31:0] coef_value,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_z,
  input  wire logic signed [31:0] in_w,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      screen_x,
  output logic signed [31:0]      screen_y,
  output logic signed [31:0]      depth_z,
  output logic signed [31:0]      clip_w,
  output logic                    divide_skipped,
  // configuration channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // dividend width: magnitude shifted up by the fraction bits
  localparam int NW = 32 + FRAC_BITS;

  // pipeline advance: free while the result register is empty or drained
  logic en;
  logic accept;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // viewport size registers
  logic [15:0] screen_width;
  logic [15:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 16'd640;
      screen_height <= 16'd480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vtp_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        vtp_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // world matrix: written on load transfer, each entry feeds its own multiplier
  logic signed [15:0][31:0] world;
  logic signed [15:0][31:0] proj;

  always_ff @(posedge clk) begin
    if (accept && op == vtp_pkg::OP_LOAD && !coef_index[4]) begin
      world[coef_index[3:0]] <= coef_value;
    end
  end

  // stage 0: world products
  logic [3:0][31:0] vin;
  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;
  assign vin[3] = in_w;

  logic                           s0_valid;
  logic                           s0_ld;
  logic [3:0]                     s0_idx;
  logic [31:0]                    s0_val;
  logic signed [3:0][3:0][63:0]   s0_term;
  logic signed [3:0][3:0][63:0]   w_term;

  always_comb begin
    logic signed [63:0] pr;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        pr = $signed(vin[r]) * $signed(world[r*4+c]);
        w_term[r][c] = pr >>> FRAC_BITS;
      end
    end
  end

  // projection loads travel with the stream so they land in order
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s0_ld    <= 1'b0;
    end else if (en) begin
      s0_valid <= accept && op == vtp_pkg::OP_VERTEX;
      s0_ld    <= accept && op == vtp_pkg::OP_LOAD && coef_index[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_idx  <= coef_index[3:0];
      s0_val  <= coef_value;
      s0_term <= w_term;
    end
  end

  // stage 1: world sums, clamped
  logic                    s1_valid;
  logic                    s1_ld;
  logic [3:0]              s1_idx;
  logic [31:0]             s1_val;
  logic signed [2:0][31:0] s1_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_ld    <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
      s1_ld    <= s0_ld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx <= s0_idx;
      s1_val <= s0_val;
      for (int c = 0; c < 3; c++) begin
        s1_a[c] <= vtp_pkg::sat32(66'($signed(s0_term[0][c])) + 66'($signed(s0_term[1][c]))
                                + 66'($signed(s0_term[2][c])) + 66'($signed(s0_term[3][c])));
      end
    end
  end

  // projection write happens where the matrix is read
  always_ff @(posedge clk) begin
    if (en && s1_ld) begin
      proj[s1_idx] <= s1_val;
    end
  end

  // stage 2: projection products, implied unit w takes row 3 as is
  logic                          s2_valid;
  logic signed [2:0][3:0][63:0]  s2_term;
  logic signed [3:0][31:0]       s2_k;
  logic signed [2:0][3:0][63:0]  p_term;

  always_comb begin
    logic signed [63:0] pr;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        pr = $signed(s1_a[r]) * $signed(proj[r*4+c]);
        p_term[r][c] = pr >>> FRAC_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_term <= p_term;
      for (int c = 0; c < 4; c++) begin
        s2_k[c] <= proj[12+c];
      end
    end
  end

  // stage 3: clip-space sums
  logic                    s3_valid;
  logic signed [3:0][31:0] s3_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        s3_p[c] <= vtp_pkg::sat32(66'($signed(s2_term[0][c])) + 66'($signed(s2_term[1][c]))
                                + 66'($signed(s2_term[2][c])) + 66'($signed(s2_k[c])));
      end
    end
  end

  // stage 4: divider operands as magnitudes, signs ride along
  logic                   s4_valid;
  logic [31:0]            s4_den;
  logic [2:0][31:0]       s4_rem;
  logic [2:0][NW-1:0]     s4_nq;
  vtp_pkg::div_side_t     s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] mag;
    if (en) begin
      // zero w: divide by one, the result is discarded anyway
      if (s3_p[3] == 32'sd0) s4_den <= 32'd1;
      else s4_den <= s3_p[3][31] ? 32'(-s3_p[3]) : 32'(s3_p[3]);
      s4_side.skip <= (s3_p[3] == 32'sd0);
      s4_side.pw   <= s3_p[3];
      for (int l = 0; l < 3; l++) begin
        mag = s3_p[l][31] ? 32'(-s3_p[l]) : 32'(s3_p[l]);
        s4_rem[l]      <= 32'd0;
        s4_nq[l]       <= NW'({mag, {FRAC_BITS{1'b0}}});
        s4_side.neg[l] <= s3_p[l][31] ^ s3_p[3][31];
        s4_side.pv[l]  <= s3_p[l];
      end
    end
  end

  // divider chain, one quotient bit per cell
  logic [NW:0]                    c_valid;
  logic [NW:0][31:0]              c_den;
  logic [NW:0][2:0][31:0]         c_rem;
  logic [NW:0][2:0][NW-1:0]       c_nq;
  vtp_pkg::div_side_t [NW:0]      c_side;

  assign c_valid[0] = s4_valid;
  assign c_den[0]   = s4_den;
  assign c_rem[0]   = s4_rem;
  assign c_nq[0]    = s4_nq;
  assign c_side[0]  = s4_side;

  for (genvar i = 0; i < NW; i++) begin : g_div
    vtp_div_cell #(.NW(NW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (c_valid[i]),
      .in_den    (c_den[i]),
      .in_rem    (c_rem[i]),
      .in_nq     (c_nq[i]),
      .in_side   (c_side[i]),
      .out_valid (c_valid[i+1]),
      .out_den   (c_den[i+1]),
      .out_rem   (c_rem[i+1]),
      .out_nq    (c_nq[i+1]),
      .out_side  (c_side[i+1])
    );
  end

  // stage e: restore sign, clamp, or pass undivided values through
  logic                    e_valid;
  logic signed [2:0][31:0] e_v;
  logic signed [31:0]      e_w;
  logic                    e_skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= c_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [NW:0] qs;
    if (en) begin
      e_w    <= c_side[NW].pw;
      e_skip <= c_side[NW].skip;
      for (int l = 0; l < 3; l++) begin
        qs = $signed({1'b0, c_nq[NW][l]});
        if (c_side[NW].neg[l]) qs = -qs;
        if (c_side[NW].skip) e_v[l] <= c_side[NW].pv[l];
        else e_v[l] <= vtp_pkg::sat32(66'(qs));
      end
    end
  end

  // viewport mapping and result register
  vtp_viewport #(.FRAC_BITS(FRAC_BITS)) u_viewport (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .in_x      (e_v[0]),
    .in_y      (e_v[1]),
    .in_z      (e_v[2]),
    .in_w      (e_w),
    .in_skip   (e_skip),
    .width     (screen_width),
    .height    (screen_height),
    .out_valid (out_valid),
    .out_x     (screen_x),
    .out_y     (screen_y),
    .out_z     (depth_z),
    .out_w     (clip_w),
    .out_skip  (divide_skipped)
  );

endmodule

`default_nettype wire

@@ rtl/vtp_div_cell.sv @@
// ----------------------------------------------------------------------------
// vtp_div_cell
// one restoring-division step for three lanes sharing a divisor
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_div_cell #(
  parameter int NW = 48
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [31:0]                in_den,
  input  wire logic [2:0][31:0]           in_rem,
  input  wire logic [2:0][NW-1:0]         in_nq,
  input  wire vtp_pkg::div_side_t         in_side,
  output logic                            out_valid,
  output logic [31:0]                     out_den,
  output logic [2:0][31:0]                out_rem,
  output logic [2:0][NW-1:0]              out_nq,
  output vtp_pkg::div_side_t              out_side
);

  logic [2:0][31:0]   rem_next;
  logic [2:0][NW-1:0] nq_next;

  always_comb begin
    logic [32:0] t;
    logic [32:0] diff;
    logic        ge;
    for (int l = 0; l < 3; l++) begin
      t    = {in_rem[l], in_nq[l][NW-1]};
      ge   = (t >= {1'b0, in_den});
      diff = t - {1'b0, in_den};
      rem_next[l] = ge ? diff[31:0] : t[31:0];
      nq_next[l]  = {in_nq[l][NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_den  <= in_den;
      out_rem  <= rem_next;
      out_nq   <= nq_next;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

@@ rtl/vtp_viewport.sv @@
// ----------------------------------------------------------------------------
// vtp_viewport
// viewport scaling of x and y and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_viewport #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_z,
  input  wire logic signed [31:0] in_w,
  input  wire logic               in_skip,
  input  wire logic [15:0]        width,
  input  wire logic [15:0]        height,
  output logic                    out_valid,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic signed [31:0]      out_w,
  output logic                    out_skip
);

  localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

  logic               m_valid;
  logic signed [50:0] m_x;
  logic signed [50:0] m_y;
  logic signed [31:0] m_z;
  logic signed [31:0] m_w;
  logic               m_skip;

  logic signed [33:0] bx;
  logic signed [33:0] by;

  assign bx = 34'(in_x) + ONE;
  assign by = 34'(in_y) + ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m_valid   <= in_valid;
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_x    <= 51'(bx * $signed({1'b0, width}));
      m_y    <= 51'(by * $signed({1'b0, height}));
      m_z    <= in_z;
      m_w    <= in_w;
      m_skip <= in_skip;
      // halve with floor, then clamp
      out_x    <= vtp_pkg::sat32(66'(m_x >>> 1));
      out_y    <= vtp_pkg::sat32(66'(m_y >>> 1));
      out_z    <= m_z;
      out_w    <= m_w;
      out_skip <= m_skip;
    end
  end

endmodule

`default_nettype wire
